FILE: rtl/core/plmc_pkg.sv
`default_nettype none

package plmc_pkg;

  // Fixed field widths of the item and result channels
  localparam int CMD_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int QUERY_W     = 6;
  localparam int NODE_W      = 7;
  localparam int COUNT_OUT_W = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RD_SRC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RD_DST  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RD_PAIR = 2'd3;

  // Result kinds
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Characters
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;

  // Tag matcher progress codes: 0..3 letters matched, then reading digits, then done
  localparam logic [2:0] PROG_IDLE = 3'd0;
  localparam logic [2:0] PROG_ONE  = 3'd1;
  localparam logic [2:0] PROG_NUM  = 3'd4;
  localparam logic [2:0] PROG_DONE = 3'd5;

  // Parsed view of the current line
  typedef struct packed {
    logic              src_found;
    logic              dst_found;
    logic [NODE_W-1:0] src_num;
    logic [NODE_W-1:0] dst_num;
  } line_t;

endpackage

`default_nettype wire

FILE: rtl/core/plmc_ram.sv
`default_nettype none

module plmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the entry being written sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/plmc_parser.sv
`default_nettype none

module plmc_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     clear,
  input  logic [plmc_pkg::BYTE_W-1:0] text_byte,
  output plmc_pkg::line_t          line
);
  import plmc_pkg::*;

  typedef struct packed {
    logic [2:0]        prog;
    logic [NODE_W-1:0] num;
    logic              seen_one;
    logic              seen_two;
  } tag_t;

  tag_t src_tag;
  tag_t dst_tag;
  tag_t src_tag_next;
  tag_t dst_tag_next;

  // Letter of the SRC: or DST: tag at a given position
  function automatic logic [BYTE_W-1:0] tag_char(logic is_dst, logic [1:0] idx);
    logic [BYTE_W-1:0] c;
    unique case (idx)
      2'd0:    c = is_dst ? 8'h44 : 8'h53;
      2'd1:    c = is_dst ? 8'h53 : 8'h52;
      2'd2:    c = is_dst ? 8'h54 : 8'h43;
      default: c = CHAR_COLON;
    endcase
    return c;
  endfunction

  // Advance one tag matcher and its number by one byte
  function automatic tag_t tag_step(tag_t s, logic [BYTE_W-1:0] b, logic is_dst);
    tag_t              n;
    logic              digit;
    logic [BYTE_W-1:0] d;
    n     = s;
    digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    d     = b - CHAR_ZERO;
    if (s.prog < PROG_NUM) begin
      if (b == tag_char(is_dst, s.prog[1:0])) begin
        n.prog = s.prog + 3'd1;
      end else if (b == tag_char(is_dst, 2'd0)) begin
        n.prog = PROG_ONE;
      end else begin
        n.prog = PROG_IDLE;
      end
    end else if (s.prog == PROG_NUM) begin
      if (!digit) begin
        n.prog = PROG_DONE;
      end else begin
        n.num = NODE_W'(10'({s.num, 3'b000}) + 10'({s.num, 1'b0}) + 10'(d[3:0]));
        if (s.seen_one) begin
          n.seen_two = 1'b1;
          n.prog     = PROG_DONE;
        end else begin
          n.seen_one = 1'b1;
        end
      end
    end
    return n;
  endfunction

  always_comb begin
    src_tag_next = tag_step(src_tag, text_byte, 1'b0);
    dst_tag_next = tag_step(dst_tag, text_byte, 1'b1);
  end

  // Hold line state; restart at each newline
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      src_tag <= '0;
      dst_tag <= '0;
    end else if (step) begin
      src_tag <= src_tag_next;
      dst_tag <= dst_tag_next;
    end
  end

  assign line.src_found = src_tag.seen_one;
  assign line.dst_found = dst_tag.seen_one;
  assign line.src_num   = src_tag.num;
  assign line.dst_num   = dst_tag.num;

endmodule

`default_nettype wire

FILE: rtl/core/packet_log_traffic_matrix_counter.sv
`default_nettype none
// Channel  | Handshake                  | Payload
// item     | item_valid / item_ready    | command, text_byte, query_source, query_destination
// result   | result_valid / result_ready| report_kind, source_found, destination_found,
//          |                            | source_node, destination_node, out_of_range,
//          |                            | count_value
//
// One item per cycle while item_ready is high. A newline or read command leaves a result
// through the synchronous counter memory read, then the saturating increment with its
// write-back into the counter memory and capture in the output register.
// Back-to-back updates of the same counter are served from a write bypass register.
// After reset a clearing pass sweeps 2^(2*ceil(log2 NODES)) pair addresses (4096 at the
// default) to zero the counters, during which no item is accepted.
// A stalled result holds the whole pipeline and lowers item_ready; so does clearing.

module packet_log_traffic_matrix_counter #(
  parameter int NODES      = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [plmc_pkg::CMD_W-1:0]        command,
  input  logic [plmc_pkg::BYTE_W-1:0]       text_byte,
  input  logic [plmc_pkg::QUERY_W-1:0]      query_source,
  input  logic [plmc_pkg::QUERY_W-1:0]      query_destination,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              report_kind,
  output logic                              source_found,
  output logic                              destination_found,
  output logic [plmc_pkg::NODE_W-1:0]       source_node,
  output logic [plmc_pkg::NODE_W-1:0]       destination_node,
  output logic                              out_of_range,
  output logic [plmc_pkg::COUNT_OUT_W-1:0]  count_value
);
  import plmc_pkg::*;

  localparam int IDX_W      = $clog2(NODES);
  localparam int PAIR_W     = 2 * IDX_W;
  localparam int SIDE_DEPTH = 1 << IDX_W;
  localparam int PAIR_DEPTH = 1 << PAIR_W;
  localparam int EXT_W      = 2 * COUNT_OUT_W;
  localparam logic [NODE_W-1:0] NODE_LIM = NODE_W'(NODES);

  typedef struct packed {
    logic              is_read;
    logic [CMD_W-1:0]  cmd;
    logic              q_ok;
    logic              src_found;
    logic              dst_found;
    logic [NODE_W-1:0] src_num;
    logic [NODE_W-1:0] dst_num;
    logic              oor;
    logic              src_ok;
    logic              dst_ok;
    logic [IDX_W-1:0]  src_addr;
    logic [IDX_W-1:0]  dst_addr;
    logic [PAIR_W-1:0] pair_addr;
  } s1_t;

  line_t line;
  logic  accept;
  logic  adv;
  logic  is_text;
  logic  is_nl;
  logic  enter_s1;
  logic  clearing;
  logic [PAIR_W-1:0] clr_addr;

  s1_t  s1;
  s1_t  s1_next;
  logic s1_valid;
  logic s1_fire;

  logic [NODE_W-1:0] sn;
  logic [NODE_W-1:0] dn;
  logic              qs_ok;
  logic              qd_ok;

  logic [COUNT_BITS-1:0] src_rdata, dst_rdata, pair_rdata;
  logic [COUNT_BITS-1:0] src_cur, dst_cur, pair_cur;
  logic [COUNT_BITS-1:0] src_inc, dst_inc, pair_inc;
  logic                  src_we, dst_we, pair_we;

  logic                  byp_src_valid, byp_dst_valid, byp_pair_valid;
  logic [IDX_W-1:0]      byp_src_addr, byp_dst_addr;
  logic [PAIR_W-1:0]     byp_pair_addr;
  logic [COUNT_BITS-1:0] byp_src_data, byp_dst_data, byp_pair_data;

  logic [COUNT_BITS-1:0] read_sel;
  logic [COUNT_BITS-1:0] read_val;
  logic [EXT_W-1:0]      read_ext;
  logic [COUNT_OUT_W-1:0] read_sat;

  // Handshake
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv && !clearing;
  assign accept     = item_valid && item_ready;
  assign is_text    = (command == CMD_TEXT);
  assign is_nl      = (text_byte == CHAR_NL);
  assign enter_s1   = accept && !(is_text && !is_nl);
  assign s1_fire    = s1_valid && adv;

  plmc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (accept && is_text && !is_nl),
    .clear     (accept && is_text && is_nl),
    .text_byte (text_byte),
    .line      (line)
  );

  // Decode the item: parsed line at a newline, query otherwise
  always_comb begin
    sn    = line.src_found ? line.src_num : '0;
    dn    = line.dst_found ? line.dst_num : '0;
    qs_ok = NODE_W'(query_source) < NODE_LIM;
    qd_ok = NODE_W'(query_destination) < NODE_LIM;

    s1_next.is_read   = !is_text;
    s1_next.cmd       = command;
    unique case (command)
      CMD_RD_SRC:  s1_next.q_ok = qs_ok;
      CMD_RD_DST:  s1_next.q_ok = qd_ok;
      CMD_RD_PAIR: s1_next.q_ok = qs_ok && qd_ok;
      default:     s1_next.q_ok = 1'b0;
    endcase
    s1_next.src_found = is_text && line.src_found;
    s1_next.dst_found = is_text && line.dst_found;
    s1_next.src_num   = is_text ? sn : '0;
    s1_next.dst_num   = is_text ? dn : '0;
    s1_next.src_ok    = is_text && line.src_found && (sn < NODE_LIM);
    s1_next.dst_ok    = is_text && line.dst_found && (dn < NODE_LIM);
    s1_next.oor       = is_text && ((line.src_found && !(sn < NODE_LIM)) ||
                                    (line.dst_found && !(dn < NODE_LIM)));
    if (is_text) begin
      s1_next.src_addr  = IDX_W'(sn);
      s1_next.dst_addr  = IDX_W'(dn);
      s1_next.pair_addr = {IDX_W'(sn), IDX_W'(dn)};
    end else begin
      s1_next.src_addr  = IDX_W'(query_source);
      s1_next.dst_addr  = IDX_W'(query_destination);
      s1_next.pair_addr = {IDX_W'(query_source), IDX_W'(query_destination)};
    end
  end

  // Advance the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= enter_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (enter_s1) begin
      s1 <= s1_next;
    end
  end

  // Sweep all counters to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + PAIR_W'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Counter memories
  plmc_ram #(.WIDTH(COUNT_BITS), .DEPTH(SIDE_DEPTH)) u_src_ram (
    .clk   (clk),
    .we    (clearing || src_we),
    .waddr (clearing ? clr_addr[IDX_W-1:0] : s1.src_addr),
    .wdata (clearing ? '0 : src_inc),
    .re    (accept),
    .raddr (s1_next.src_addr),
    .rdata (src_rdata)
  );

  plmc_ram #(.WIDTH(COUNT_BITS), .DEPTH(SIDE_DEPTH)) u_dst_ram (
    .clk   (clk),
    .we    (clearing || dst_we),
    .waddr (clearing ? clr_addr[IDX_W-1:0] : s1.dst_addr),
    .wdata (clearing ? '0 : dst_inc),
    .re    (accept),
    .raddr (s1_next.dst_addr),
    .rdata (dst_rdata)
  );

  plmc_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (clearing || pair_we),
    .waddr (clearing ? clr_addr : s1.pair_addr),
    .wdata (clearing ? '0 : pair_inc),
    .re    (accept),
    .raddr (s1_next.pair_addr),
    .rdata (pair_rdata)
  );

  // Forward the previous write, then increment with saturation
  always_comb begin
    src_cur  = (byp_src_valid && byp_src_addr == s1.src_addr) ? byp_src_data : src_rdata;
    dst_cur  = (byp_dst_valid && byp_dst_addr == s1.dst_addr) ? byp_dst_data : dst_rdata;
    pair_cur = (byp_pair_valid && byp_pair_addr == s1.pair_addr) ?
               byp_pair_data : pair_rdata;
    src_inc  = (src_cur == '1) ? src_cur : src_cur + COUNT_BITS'(1);
    dst_inc  = (dst_cur == '1) ? dst_cur : dst_cur + COUNT_BITS'(1);
    pair_inc = (pair_cur == '1) ? pair_cur : pair_cur + COUNT_BITS'(1);
    src_we   = s1_fire && !s1.is_read && s1.src_ok;
    dst_we   = s1_fire && !s1.is_read && s1.dst_ok;
    pair_we  = s1_fire && !s1.is_read && s1.src_ok && s1.dst_ok;
  end

  // Hold the last write of each memory for the item read in the same cycle
  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      byp_src_valid  <= 1'b0;
      byp_dst_valid  <= 1'b0;
      byp_pair_valid <= 1'b0;
    end else if (adv) begin
      byp_src_valid  <= src_we;
      byp_dst_valid  <= dst_we;
      byp_pair_valid <= pair_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byp_src_addr  <= s1.src_addr;
      byp_dst_addr  <= s1.dst_addr;
      byp_pair_addr <= s1.pair_addr;
      byp_src_data  <= src_inc;
      byp_dst_data  <= dst_inc;
      byp_pair_data <= pair_inc;
    end
  end

  // Select the counter a read asks for, zero it for an out-of-range query, and clamp it
  always_comb begin
    unique case (s1.cmd)
      CMD_RD_SRC:  read_sel = src_cur;
      CMD_RD_DST:  read_sel = dst_cur;
      CMD_RD_PAIR: read_sel = pair_cur;
      default:     read_sel = '0;
    endcase
    read_val = s1.q_ok ? read_sel : '0;
    read_ext = EXT_W'(read_val);
    read_sat = (read_ext[EXT_W-1:COUNT_OUT_W] != '0) ? '1 : read_ext[COUNT_OUT_W-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      report_kind       <= s1.is_read ? KIND_READ : KIND_LINE;
      source_found      <= s1.src_found;
      destination_found <= s1.dst_found;
      source_node       <= s1.src_num;
      destination_node  <= s1.dst_num;
      out_of_range      <= s1.oor;
      count_value       <= s1.is_read ? read_sat : '0;
    end
  end

  // No item is in flight while the counters are swept
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid)
    else $error("item in flight during counter clearing");

  // A pair count moves only together with both node counts
  a_pair_with_nodes: assert property (@(posedge clk) disable iff (rst)
    pair_we |-> (src_we && dst_we))
    else $error("pair counter written without node counters");

  // Each source write is captured for forwarding
  a_src_bypass: assert property (@(posedge clk) disable iff (rst)
    src_we |=> (byp_src_valid && byp_src_data == $past(src_inc)))
    else $error("source write not held in bypass");

  // A line report carries no count
  a_line_no_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && report_kind == KIND_LINE) |-> (count_value == '0))
    else $error("line report with nonzero count");

  // A read answer carries no parse flags
  a_read_no_flags: assert property (@(posedge clk) disable iff (rst)
    (result_valid && report_kind == KIND_READ) |->
      (!source_found && !destination_found && !out_of_range))
    else $error("read answer with parse flags");

endmodule

`default_nettype wire
